// File: design/stog_pkg.sv
// Shared types, register codes and CORDIC constants of the scan-to-grid block.
`timescale 1ns / 1ps
`default_nettype none
package stog_pkg;

	// Input operation codes
	localparam logic [1:0] OP_BEAM = 2'd0;
	localparam logic [1:0] OP_MARK = 2'd1;
	localparam logic [1:0] OP_END  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_ANGLE_START = 2'd0;
	localparam logic [1:0] CFG_ANGLE_STEP  = 2'd1;
	localparam logic [1:0] CFG_CELL_SCALE  = 2'd2;

	localparam logic [15:0] ANGLE_START_RST = 16'hC000;
	localparam logic [15:0] ANGLE_STEP_RST  = 16'd64;
	localparam logic [23:0] CELL_SCALE_RST  = 24'd83886;

	// CORDIC: angles in 2^24 per turn, results in Q16
	localparam int CORDIC_STEPS = 16;
	localparam int Z_W          = 25;
	localparam int XY_W         = 20;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN  = 20'sd39797;
	localparam logic signed [Z_W-1:0]  QUARTER_TURN = 25'sd4194304;
	localparam logic signed [Z_W-1:0]  HALF_TURN    = 25'sd8388608;

	typedef struct packed {
		logic [1:0]         op;
		logic [11:0]        beam_index;
		logic [15:0]        range_mm;
		logic signed [15:0] point_x_mm;
		logic signed [15:0] point_y_mm;
	} in_beat_t;

	typedef struct packed {
		logic [5:0]  row_number;
		logic [63:0] row_cells;
		logic        last_row;
	} out_beat_t;

	typedef struct packed {
		logic signed [15:0] angle_start;
		logic [15:0]        angle_step;
		logic [23:0]        cell_scale;
	} cfg_t;

	typedef enum logic [1:0] {
		JOB_BEAM,
		JOB_MARK,
		JOB_END
	} job_kind_t;

	typedef struct packed {
		job_kind_t          kind;
		logic [15:0]        theta;
		logic [15:0]        range_mm;
		logic signed [15:0] point_x_mm;
		logic signed [15:0] point_y_mm;
	} job_t;

	function automatic logic signed [Z_W-1:0] cordic_atan(input logic [3:0] idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			4'd0:  v = 25'sd2097152;
			4'd1:  v = 25'sd1238021;
			4'd2:  v = 25'sd654136;
			4'd3:  v = 25'sd332050;
			4'd4:  v = 25'sd166669;
			4'd5:  v = 25'sd83416;
			4'd6:  v = 25'sd41718;
			4'd7:  v = 25'sd20860;
			4'd8:  v = 25'sd10430;
			4'd9:  v = 25'sd5215;
			4'd10: v = 25'sd2608;
			4'd11: v = 25'sd1304;
			4'd12: v = 25'sd652;
			4'd13: v = 25'sd326;
			4'd14: v = 25'sd163;
			4'd15: v = 25'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: design/stog_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module stog_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]              rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// File: design/stog_front.sv
// Front end: accepts beats, drops unused ops, forms the beam angle, feeds the queue.
`timescale 1ns / 1ps
`default_nettype none
module stog_front import stog_pkg::*; (
	input  wire logic     in_valid,
	input  wire in_beat_t in_data,
	output logic          in_stall,
	input  wire cfg_t     cfg,
	input  wire logic     queue_full,
	output logic          push_en,
	output job_t          push_job
);
	logic [27:0] step_prod;

	always_comb begin
		step_prod = 28'(in_data.beam_index) * 28'(cfg.angle_step);
		push_job.theta      = $unsigned(cfg.angle_start) + step_prod[15:0];
		push_job.range_mm   = in_data.range_mm;
		push_job.point_x_mm = in_data.point_x_mm;
		push_job.point_y_mm = in_data.point_y_mm;
		push_en             = in_valid && !queue_full;
		case (in_data.op)
			OP_BEAM: push_job.kind = JOB_BEAM;
			OP_MARK: push_job.kind = JOB_MARK;
			OP_END:  push_job.kind = JOB_END;
			default: begin
				// unused op: taken and dropped
				push_job.kind = JOB_END;
				push_en       = 1'b0;
			end
		endcase
	end

	assign in_stall = queue_full;
endmodule
`default_nettype wire

// File: design/stog_fifo.sv
// Short job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module stog_fifo import stog_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_en,
	input  wire job_t push_job,
	input  wire logic pop_en,
	output job_t      pop_job,
	output logic      full,
	output logic      empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push_en && !full;
	assign do_pop  = pop_en && !empty;
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// File: design/stog_back.sv
// Back end: CORDIC, scaling, cell index, grid read-modify-write and row dump.
`timescale 1ns / 1ps
`default_nettype none
module stog_back import stog_pkg::*; #(
	parameter int GRID_SIDE = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire job_t pop_job,
	input  wire logic queue_empty,
	output logic      pop_en,
	output logic      out_valid,
	output out_beat_t out_data,
	input  wire logic out_stall
);
	localparam int ROW_W     = $clog2(GRID_SIDE);
	localparam int CELL_W    = $clog2(GRID_SIDE * GRID_SIDE);
	localparam int DIV_SHIFT = CELL_W + 1;
	localparam int DIV_RECIP = (1 << DIV_SHIFT) / GRID_SIDE;
	localparam int HALF      = GRID_SIDE / 2;
	localparam logic signed [60:0] HALF_Q40 = 61'(HALF) << 40;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROT, ST_RANGE, ST_PROD, ST_SUM, ST_INDEX,
		ST_K, ST_DIV, ST_FIX, ST_RD, ST_WR, ST_DRD, ST_DOUT
	} state_t;

	state_t                 state_q;
	job_t                   job_q;
	logic [3:0]             step_q;
	logic signed [XY_W-1:0] cx_q, cy_q;
	logic signed [Z_W-1:0]  z_q;
	logic                   neg_q;
	logic signed [33:0]     mx_q, my_q;
	logic [40:0]            plx_q, ply_q;
	logic signed [41:0]     phx_q, phy_q;
	logic signed [58:0]     px_q, py_q;
	logic signed [21:0]     xi_q, yi_q;
	logic [CELL_W-1:0]      kc_q;
	logic [ROW_W-1:0]       qe_q, row_q, col_q;
	logic [GRID_SIDE-1:0]   rv_q;
	logic                   out_valid_q;
	out_beat_t              out_q;

	// combinational helpers
	logic signed [XY_W-1:0]      dx, dy, cfx, cfy;
	logic signed [Z_W-1:0]       atan_v, z_init;
	logic signed [16:0]          rng_s, mhx, mhy;
	logic signed [36:0]          mxw, myw;
	logic signed [24:0]          scale_s;
	logic signed [41:0]          phxw, phyw;
	logic [40:0]                 plxw, plyw;
	logic [58:0]                 pxa;
	logic signed [60:0]          vy;
	logic [60:0]                 vya;
	logic signed [31:0]          ka, kw;
	logic [CELL_W+DIV_SHIFT-1:0] qprod;
	logic [CELL_W-1:0]           qmul, rem;
	logic [GRID_SIDE-1:0]        rd_data, row_now;
	logic                        ram_wr, ram_rd, dout_take;
	logic [ROW_W-1:0]            ram_addr;

	always_comb begin
		dx      = cy_q >>> step_q;
		dy      = cx_q >>> step_q;
		atan_v  = cordic_atan(step_q);
		z_init  = Z_W'($signed({pop_job.theta, 8'b0}));
		cfx     = neg_q ? -cx_q : cx_q;
		cfy     = neg_q ? -cy_q : cy_q;
		rng_s   = $signed({1'b0, job_q.range_mm});
		mxw     = rng_s * cfx;
		myw     = rng_s * cfy;
		scale_s = $signed({1'b0, cfg.cell_scale});
		mhx     = mx_q[33:17];
		mhy     = my_q[33:17];
		phxw    = mhx * scale_s;
		phyw    = mhy * scale_s;
		plxw    = mx_q[16:0] * cfg.cell_scale;
		plyw    = my_q[16:0] * cfg.cell_scale;
		pxa     = px_q[58] ? $unsigned(-px_q) : $unsigned(px_q);
		vy      = HALF_Q40 - 61'(py_q);
		vya     = vy[60] ? $unsigned(-vy) : $unsigned(vy);
		ka      = 32'(HALF - 1) - 32'(xi_q);
		kw      = ka * $signed(32'(GRID_SIDE)) + 32'(yi_q);
		qprod   = (CELL_W + DIV_SHIFT)'(kc_q) * (CELL_W + DIV_SHIFT)'(DIV_RECIP);
		qmul    = CELL_W'(qe_q) * CELL_W'(GRID_SIDE);
		rem     = kc_q - qmul;
		row_now = rv_q[row_q] ? rd_data : '0;
	end

	assign pop_en    = (state_q == ST_IDLE) && !queue_empty;
	assign ram_rd    = (state_q == ST_RD) || (state_q == ST_DRD);
	assign ram_wr    = (state_q == ST_WR);
	assign ram_addr  = row_q;
	assign dout_take = (state_q == ST_DOUT) && (!out_valid_q || !out_stall);

	stog_ram #(.WIDTH(GRID_SIDE), .DEPTH(GRID_SIDE)) u_grid (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (ram_addr),
		.wr_data (row_now | ({{(GRID_SIDE-1){1'b0}}, 1'b1} << col_q)),
		.rd_en   (ram_rd),
		.rd_addr (ram_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rv_q        <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			row_q       <= '0;
		end else begin
			// a new row in the same cycle keeps valid high below
			if (out_valid_q && !out_stall && !dout_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						job_q <= pop_job;
						case (pop_job.kind)
							JOB_BEAM: begin
								cx_q   <= CORDIC_GAIN;
								cy_q   <= '0;
								step_q <= '0;
								if (z_init > QUARTER_TURN) begin
									z_q   <= z_init - HALF_TURN;
									neg_q <= 1'b1;
								end else if (z_init < -QUARTER_TURN) begin
									z_q   <= z_init + HALF_TURN;
									neg_q <= 1'b1;
								end else begin
									z_q   <= z_init;
									neg_q <= 1'b0;
								end
								state_q <= ST_ROT;
							end
							JOB_MARK: begin
								mx_q    <= {{2{pop_job.point_x_mm[15]}}, pop_job.point_x_mm, 16'b0};
								my_q    <= {{2{pop_job.point_y_mm[15]}}, pop_job.point_y_mm, 16'b0};
								state_q <= ST_PROD;
							end
							JOB_END: begin
								row_q   <= '0;
								state_q <= ST_DRD;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ROT: begin
					if (!z_q[Z_W-1]) begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						z_q  <= z_q - atan_v;
					end else begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						z_q  <= z_q + atan_v;
					end
					step_q <= step_q + 1'b1;
					if (step_q == 4'(CORDIC_STEPS - 1)) begin
						state_q <= ST_RANGE;
					end
				end
				ST_RANGE: begin
					mx_q    <= mxw[33:0];
					my_q    <= myw[33:0];
					state_q <= ST_PROD;
				end
				ST_PROD: begin
					phx_q   <= phxw;
					phy_q   <= phyw;
					plx_q   <= plxw;
					ply_q   <= plyw;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					px_q    <= $signed({phx_q, 17'b0}) + $signed({18'b0, plx_q});
					py_q    <= $signed({phy_q, 17'b0}) + $signed({18'b0, ply_q});
					state_q <= ST_INDEX;
				end
				ST_INDEX: begin
					// divide by 2^40, rounding toward zero
					xi_q    <= px_q[58] ? -$signed(22'(pxa[58:40])) : $signed(22'(pxa[58:40]));
					yi_q    <= vy[60] ? -$signed(22'(vya[60:40])) : $signed(22'(vya[60:40]));
					state_q <= ST_K;
				end
				ST_K: begin
					kc_q <= kw[CELL_W-1:0];
					if (kw >= 0 && kw < 32'(GRID_SIDE * GRID_SIDE)) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					// reciprocal estimate, low by at most one
					qe_q    <= qprod[DIV_SHIFT +: ROW_W];
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (rem >= CELL_W'(GRID_SIDE)) begin
						row_q <= qe_q + 1'b1;
						col_q <= ROW_W'(rem - CELL_W'(GRID_SIDE));
					end else begin
						row_q <= qe_q;
						col_q <= ROW_W'(rem);
					end
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					rv_q[row_q] <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_DRD: state_q <= ST_DOUT;
				ST_DOUT: begin
					if (dout_take) begin
						out_valid_q      <= 1'b1;
						out_q.row_number <= 6'(row_q);
						out_q.row_cells  <= 64'(row_now);
						out_q.last_row   <= (row_q == ROW_W'(GRID_SIDE - 1));
						rv_q[row_q]      <= 1'b0;
						if (row_q == ROW_W'(GRID_SIDE - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_DRD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.last_row == (out_q.row_number == 6'(GRID_SIDE - 1))))
		else $error("last_row flag does not match row number");

	a_mark_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |=> rv_q[$past(row_q)])
		else $error("written row not marked valid");

	a_dump_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(dout_take && row_q == ROW_W'(GRID_SIDE - 1)) |=> (rv_q == '0 && state_q == ST_IDLE))
		else $error("grid not clear after frame dump");
endmodule
`default_nettype wire

// File: design/scan_to_occupancy_grid.sv
// Top level of the laser-scan to occupancy-grid rasterizer.
`timescale 1ns / 1ps
`default_nettype none
// Rasterizes one frame of laser beams and marker points into a GRID_SIDE x
// GRID_SIDE occupancy bitmap. Op 0 beats (beam index, range) are rotated by a
// 16-step iterative CORDIC, op 1 beats (marker x/y in mm) go straight to
// scaling; both are scaled by cell_scale and set one cell if the linear index
// lands inside the grid. Op 2 dumps every row in order, row 0 first, last_row
// on the final one, and clears the grid; op 3 is taken and dropped. The front
// accepts a beat per cycle into a QUEUE_DEPTH-entry job queue; in_stall rises
// only while that queue is full. The back works one job at a time: a beam
// runs through the CORDIC, one step per cycle, then scaling, index, division
// by GRID_SIDE and a read-modify-write of one grid row; a marker starts at
// scaling; a dump reads each row (registered grid RAM read) and sends it,
// held back by out_stall. The grid clears at reset through per-row valid
// bits, so no clearing pass is needed. Write configuration only while idle.
module scan_to_occupancy_grid import stog_pkg::*; #(
	parameter int GRID_SIDE   = 64,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire in_beat_t  in_data,
	output logic           in_stall,
	output logic           out_valid,
	output out_beat_t      out_data,
	input  wire logic      out_stall,
	input  wire logic      cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	cfg_t cfg_q;
	logic push_en, pop_en, q_full, q_empty;
	job_t push_job, pop_job;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_start <= $signed(ANGLE_START_RST);
			cfg_q.angle_step  <= ANGLE_STEP_RST;
			cfg_q.cell_scale  <= CELL_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ANGLE_START: cfg_q.angle_start <= $signed(cfg_data[15:0]);
				CFG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data[15:0];
				CFG_CELL_SCALE:  cfg_q.cell_scale  <= cfg_data;
				default: ;
			endcase
		end
	end

	stog_front u_front (
		.in_valid   (in_valid),
		.in_data    (in_data),
		.in_stall   (in_stall),
		.cfg        (cfg_q),
		.queue_full (q_full),
		.push_en    (push_en),
		.push_job   (push_job)
	);

	stog_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_en  (push_en),
		.push_job (push_job),
		.pop_en   (pop_en),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	stog_back #(.GRID_SIDE(GRID_SIDE)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pop_job     (pop_job),
		.queue_empty (q_empty),
		.pop_en      (pop_en),
		.out_valid   (out_valid),
		.out_data    (out_data),
		.out_stall   (out_stall)
	);
endmodule
`default_nettype wire
